// ===== rtl/pbcf_pkg.sv =====
package pbcf_pkg;

   localparam int COORD_WIDTH     = 20;
   localparam int COEF_FRAC_BITS  = 14;
   localparam int COEF_WIDTH      = 16;
   localparam int INTENSITY_WIDTH = 16;
   localparam int NUM_AXES        = 3;

   localparam int ROT_REG_WIDTH   = NUM_AXES * COEF_WIDTH;
   localparam int BOX_REG_WIDTH   = NUM_AXES * COORD_WIDTH;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam int PROD_WIDTH   = COEF_WIDTH + COORD_WIDTH;
   localparam int SCALED_WIDTH = COORD_WIDTH + COEF_FRAC_BITS;
   localparam int ACC_WIDTH    =
      ((PROD_WIDTH > SCALED_WIDTH) ? PROD_WIDTH : SCALED_WIDTH) + 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_ROT_ROW_X,
      REG_ROT_ROW_Y,
      REG_ROT_ROW_Z,
      REG_TRANSLATION,
      REG_ROI_LOW_CORNER,
      REG_ROI_HIGH_CORNER,
      REG_BODY_LOW_CORNER,
      REG_BODY_HIGH_CORNER
   } reg_index_type;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [COEF_WIDTH-1:0]  coef_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [ACC_WIDTH-1:0]   acc_type;

   typedef struct packed {
      coord_type                  x;
      coord_type                  y;
      coord_type                  z;
      logic [INTENSITY_WIDTH-1:0] intensity;
   } point_type;

   typedef struct packed {
      logic [NUM_AXES-1:0][ROT_REG_WIDTH-1:0] rot;
      logic [BOX_REG_WIDTH-1:0]               trans;
      logic [BOX_REG_WIDTH-1:0]               roi_low;
      logic [BOX_REG_WIDTH-1:0]               roi_high;
      logic [BOX_REG_WIDTH-1:0]               body_low;
      logic [BOX_REG_WIDTH-1:0]               body_high;
   } cfg_type;

   function automatic coord_type box_field(input logic [BOX_REG_WIDTH-1:0] r,
                                           input int unsigned a);
      return coord_type'(r[a*COORD_WIDTH +: COORD_WIDTH]);
   endfunction

   function automatic coef_type coef_field(input logic [ROT_REG_WIDTH-1:0] r,
                                           input int unsigned k);
      return coef_type'(r[k*COEF_WIDTH +: COEF_WIDTH]);
   endfunction

   function automatic coord_type point_coord(input point_type p, input int unsigned a);
      coord_type v;
      case (a)
         0:       v = p.x;
         1:       v = p.y;
         default: v = p.z;
      endcase
      return v;
   endfunction

   // strict test of the untransformed point against the kept region
   function automatic logic roi_hit(input point_type p, input cfg_type c);
      logic      hit;
      coord_type v;
      hit = 1'b1;
      for (int unsigned a = 0; a < NUM_AXES; a++) begin
         v = point_coord(p, a);
         if (!((v > box_field(c.roi_low, a)) && (v < box_field(c.roi_high, a)))) begin
            hit = 1'b0;
         end
      end
      return hit;
   endfunction

endpackage

// ===== rtl/point_box_clip_filter_unit.sv =====
// channel   direction  ports
// request   in         req_valid, req_ready, req_point_x/y/z, req_point_intensity
// response  out        rsp_valid, rsp_ready, rsp_out_x/y/z, rsp_out_intensity
// csr       in         csr_valid, csr_ready, csr_index, csr_wdata
//
// one request per cycle unless a stalled response has filled the pipe; three register
// stages: input, products, response; a kept point passes through all three to rsp and
// leaves when rsp_ready is high; a dropped point leaves no response
// reset (synchronous) empties the stages and loads identity rotation, zero boxes
// a stalled response holds the pipe; req_ready falls only when every stage is full
module point_box_clip_filter_unit (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [pbcf_pkg::COORD_WIDTH-1:0]     req_point_x,
   input  logic signed [pbcf_pkg::COORD_WIDTH-1:0]     req_point_y,
   input  logic signed [pbcf_pkg::COORD_WIDTH-1:0]     req_point_z,
   input  logic        [pbcf_pkg::INTENSITY_WIDTH-1:0] req_point_intensity,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [pbcf_pkg::COORD_WIDTH-1:0]     rsp_out_x,
   output logic signed [pbcf_pkg::COORD_WIDTH-1:0]     rsp_out_y,
   output logic signed [pbcf_pkg::COORD_WIDTH-1:0]     rsp_out_z,
   output logic        [pbcf_pkg::INTENSITY_WIDTH-1:0] rsp_out_intensity,

   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pbcf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [pbcf_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   pbcf_pkg::cfg_type cfg;

   pbcf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // stage a: input register
   logic                a_valid_ff, a_valid_in;
   pbcf_pkg::point_type a_point_ff;
   // stage b: products and region result
   logic                b_valid_ff, b_valid_in;
   pbcf_pkg::point_type b_point_ff;
   logic                b_roi_ff;
   pbcf_pkg::prod_type  b_prod_ff [pbcf_pkg::NUM_AXES][pbcf_pkg::NUM_AXES];
   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   pbcf_pkg::point_type rsp_point_ff;

   pbcf_pkg::point_type req_point;
   pbcf_pkg::prod_type  a_prod [pbcf_pkg::NUM_AXES][pbcf_pkg::NUM_AXES];
   logic                a_roi;
   logic                b_body;
   logic                b_keep;
   logic                req_take, out_free, a_go, b_go, b_free;

   assign req_point.x         = req_point_x;
   assign req_point.y         = req_point_y;
   assign req_point.z         = req_point_z;
   assign req_point.intensity = req_point_intensity;

   // multiplies for stage a
   always_comb begin
      for (int unsigned a = 0; a < pbcf_pkg::NUM_AXES; a++) begin
         for (int unsigned k = 0; k < pbcf_pkg::NUM_AXES; k++) begin
            a_prod[a][k] = pbcf_pkg::prod_type'(pbcf_pkg::coef_field(cfg.rot[a], k))
                         * pbcf_pkg::prod_type'(pbcf_pkg::point_coord(a_point_ff, k));
         end
      end
   end

   assign a_roi = pbcf_pkg::roi_hit(a_point_ff, cfg);

   // sums and strict body test in the transformed frame
   always_comb begin
      logic signed [pbcf_pkg::SCALED_WIDTH-1:0] t_s;
      logic signed [pbcf_pkg::SCALED_WIDTH-1:0] lo_s;
      logic signed [pbcf_pkg::SCALED_WIDTH-1:0] hi_s;
      pbcf_pkg::acc_type                        acc;
      b_body = 1'b1;
      for (int unsigned a = 0; a < pbcf_pkg::NUM_AXES; a++) begin
         t_s  = {pbcf_pkg::box_field(cfg.trans, a), {pbcf_pkg::COEF_FRAC_BITS{1'b0}}};
         lo_s = {pbcf_pkg::box_field(cfg.body_low, a), {pbcf_pkg::COEF_FRAC_BITS{1'b0}}};
         hi_s = {pbcf_pkg::box_field(cfg.body_high, a), {pbcf_pkg::COEF_FRAC_BITS{1'b0}}};
         acc  = pbcf_pkg::ACC_WIDTH'(t_s)
              + pbcf_pkg::ACC_WIDTH'(b_prod_ff[a][0])
              + pbcf_pkg::ACC_WIDTH'(b_prod_ff[a][1])
              + pbcf_pkg::ACC_WIDTH'(b_prod_ff[a][2]);
         if (!((acc > pbcf_pkg::ACC_WIDTH'(lo_s)) && (acc < pbcf_pkg::ACC_WIDTH'(hi_s)))) begin
            b_body = 1'b0;
         end
      end
   end

   assign b_keep = b_roi_ff && !b_body;

   // flow control; a dropped point leaves stage b without waiting
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign b_go      = b_valid_ff && (out_free || !b_keep);
   assign b_free    = !b_valid_ff || b_go;
   assign a_go      = a_valid_ff && b_free;
   assign req_ready = !a_valid_ff || a_go;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_take) begin
         a_valid_in = 1'b1;
      end else if (a_go) begin
         a_valid_in = 1'b0;
      end
      b_valid_in = b_valid_ff;
      if (a_go) begin
         b_valid_in = 1'b1;
      end else if (b_go) begin
         b_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (b_go && b_keep) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_point_ff <= req_point;
      end
      if (a_go) begin
         b_point_ff <= a_point_ff;
         b_roi_ff   <= a_roi;
         b_prod_ff  <= a_prod;
      end
      if (b_go && b_keep) begin
         rsp_point_ff <= b_point_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_x         = rsp_point_ff.x;
   assign rsp_out_y         = rsp_point_ff.y;
   assign rsp_out_z         = rsp_point_ff.z;
   assign rsp_out_intensity = rsp_point_ff.intensity;

   // a full input stage that cannot advance must refuse new requests
   assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !b_free) |-> !req_ready)
      else $error("request taken while input stage blocked");

   // a kept point leaving stage b must land in the response register
   assert property (@(posedge clock) disable iff (reset)
      (b_go && b_keep) |=> rsp_valid_ff)
      else $error("kept point lost at response register");

   // anything presented must lie inside the kept region
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> pbcf_pkg::roi_hit(rsp_point_ff, cfg))
      else $error("response outside region of interest");

   // a taken request always occupies the input stage next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> a_valid_ff)
      else $error("accepted request not held");

endmodule

// ===== rtl/pbcf_csr.sv =====
module pbcf_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pbcf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [pbcf_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output pbcf_pkg::cfg_type                    cfg
);

   pbcf_pkg::cfg_type cfg_ff;
   pbcf_pkg::cfg_type cfg_in;

   logic [pbcf_pkg::BOX_REG_WIDTH+pbcf_pkg::CSR_DATA_WIDTH-1:0] box_wide;
   logic [pbcf_pkg::ROT_REG_WIDTH+pbcf_pkg::CSR_DATA_WIDTH-1:0] rot_wide;
   logic [pbcf_pkg::BOX_REG_WIDTH-1:0]                          box_data;
   logic [pbcf_pkg::ROT_REG_WIDTH-1:0]                          rot_data;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // zero extend then trim to the register width
   assign box_wide = {{pbcf_pkg::BOX_REG_WIDTH{1'b0}}, csr_wdata};
   assign rot_wide = {{pbcf_pkg::ROT_REG_WIDTH{1'b0}}, csr_wdata};
   assign box_data = box_wide[pbcf_pkg::BOX_REG_WIDTH-1:0];
   assign rot_data = rot_wide[pbcf_pkg::ROT_REG_WIDTH-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (pbcf_pkg::reg_index_type'(csr_index))
            pbcf_pkg::REG_ROT_ROW_X:        cfg_in.rot[0]    = rot_data;
            pbcf_pkg::REG_ROT_ROW_Y:        cfg_in.rot[1]    = rot_data;
            pbcf_pkg::REG_ROT_ROW_Z:        cfg_in.rot[2]    = rot_data;
            pbcf_pkg::REG_TRANSLATION:      cfg_in.trans     = box_data;
            pbcf_pkg::REG_ROI_LOW_CORNER:   cfg_in.roi_low   = box_data;
            pbcf_pkg::REG_ROI_HIGH_CORNER:  cfg_in.roi_high  = box_data;
            pbcf_pkg::REG_BODY_LOW_CORNER:  cfg_in.body_low  = box_data;
            pbcf_pkg::REG_BODY_HIGH_CORNER: cfg_in.body_high = box_data;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // identity rotation, everything else zero
         for (int a = 0; a < pbcf_pkg::NUM_AXES; a++) begin
            cfg_ff.rot[a] <= pbcf_pkg::ROT_REG_WIDTH'(1)
                             << (pbcf_pkg::COEF_FRAC_BITS + a * pbcf_pkg::COEF_WIDTH);
         end
         cfg_ff.trans     <= '0;
         cfg_ff.roi_low   <= '0;
         cfg_ff.roi_high  <= '0;
         cfg_ff.body_low  <= '0;
         cfg_ff.body_high <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== bench/point_box_clip_filter_unit_test.sv =====
module point_box_clip_filter_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pbcf_pkg::*;

   localparam int     STALL_LIMIT   = 2000;
   localparam int     SETTLE_CYCLES = 8;
   localparam int     PHASES        = 7;
   localparam int     PHASE_POINTS  = 150;
   localparam longint COEF_SCALE    = longint'(1) << COEF_FRAC_BITS;
   localparam int     COORD_MAX     = (1 << (COORD_WIDTH - 1)) - 1;
   localparam int     COORD_MIN     = -(1 << (COORD_WIDTH - 1));
   localparam int     COEF_MAX      = (1 << (COEF_WIDTH - 1)) - 1;
   localparam int     COEF_MIN      = -(1 << (COEF_WIDTH - 1));

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_ready;
   coord_type                  req_point_x = '0;
   coord_type                  req_point_y = '0;
   coord_type                  req_point_z = '0;
   logic [INTENSITY_WIDTH-1:0] req_point_intensity = '0;

   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   coord_type                  rsp_out_x;
   coord_type                  rsp_out_y;
   coord_type                  rsp_out_z;
   logic [INTENSITY_WIDTH-1:0] rsp_out_intensity;

   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // shadow of the register file, updated as each write is taken
   logic [ROT_REG_WIDTH-1:0]   rot_row [NUM_AXES];
   logic [BOX_REG_WIDTH-1:0]   shift_mm;
   logic [BOX_REG_WIDTH-1:0]   roi_lo;
   logic [BOX_REG_WIDTH-1:0]   roi_hi;
   logic [BOX_REG_WIDTH-1:0]   body_lo;
   logic [BOX_REG_WIDTH-1:0]   body_hi;

   point_type kept_points [$];
   int        error_count = 0;
   int        req_gap_max = 0;
   int        rsp_gap_max = 0;

   point_box_clip_filter_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_point_x         (req_point_x),
      .req_point_y         (req_point_y),
      .req_point_z         (req_point_z),
      .req_point_intensity (req_point_intensity),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_x           (rsp_out_x),
      .rsp_out_y           (rsp_out_y),
      .rsp_out_z           (rsp_out_z),
      .rsp_out_intensity   (rsp_out_intensity),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [BOX_REG_WIDTH-1:0] box3(input int x, input int y, input int z);
      return {coord_type'(z), coord_type'(y), coord_type'(x)};
   endfunction

   function automatic logic [ROT_REG_WIDTH-1:0] row3(input int c0, input int c1, input int c2);
      return {coef_type'(c2), coef_type'(c1), coef_type'(c0)};
   endfunction

   function automatic point_type make_point(input int x, input int y, input int z,
                                            input int level);
      point_type p;
      p.x         = coord_type'(x);
      p.y         = coord_type'(y);
      p.z         = coord_type'(z);
      p.intensity = INTENSITY_WIDTH'(level);
      return p;
   endfunction

   function automatic int draw_gap(input int top);
      return (top == 0) ? 0 : int'($urandom_range(0, top));
   endfunction

   // a point survives when its transformed position is outside the body box
   // and its raw position is strictly inside the kept region
   function automatic bit point_survives(input point_type p);
      longint    pt [NUM_AXES];
      longint    acc;
      coord_type lo_c;
      coord_type hi_c;
      coord_type t_c;
      coef_type  c;
      bit        in_body;
      bit        in_roi;
      pt[0]   = p.x;
      pt[1]   = p.y;
      pt[2]   = p.z;
      in_body = 1'b1;
      in_roi  = 1'b1;
      for (int a = 0; a < NUM_AXES; a++) begin
         t_c = shift_mm[a*COORD_WIDTH +: COORD_WIDTH];
         acc = longint'(t_c) * COEF_SCALE;
         for (int k = 0; k < NUM_AXES; k++) begin
            c   = rot_row[a][k*COEF_WIDTH +: COEF_WIDTH];
            acc += longint'(c) * pt[k];
         end
         lo_c = body_lo[a*COORD_WIDTH +: COORD_WIDTH];
         hi_c = body_hi[a*COORD_WIDTH +: COORD_WIDTH];
         if (!(acc > longint'(lo_c) * COEF_SCALE && acc < longint'(hi_c) * COEF_SCALE)) begin
            in_body = 1'b0;
         end
         lo_c = roi_lo[a*COORD_WIDTH +: COORD_WIDTH];
         hi_c = roi_hi[a*COORD_WIDTH +: COORD_WIDTH];
         if (!(pt[a] > longint'(lo_c) && pt[a] < longint'(hi_c))) begin
            in_roi = 1'b0;
         end
      end
      return !in_body && in_roi;
   endfunction

   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      case (idx)
         REG_ROT_ROW_X:        rot_row[0] = data[ROT_REG_WIDTH-1:0];
         REG_ROT_ROW_Y:        rot_row[1] = data[ROT_REG_WIDTH-1:0];
         REG_ROT_ROW_Z:        rot_row[2] = data[ROT_REG_WIDTH-1:0];
         REG_TRANSLATION:      shift_mm   = data[BOX_REG_WIDTH-1:0];
         REG_ROI_LOW_CORNER:   roi_lo     = data[BOX_REG_WIDTH-1:0];
         REG_ROI_HIGH_CORNER:  roi_hi     = data[BOX_REG_WIDTH-1:0];
         REG_BODY_LOW_CORNER:  body_lo    = data[BOX_REG_WIDTH-1:0];
         REG_BODY_HIGH_CORNER: body_hi    = data[BOX_REG_WIDTH-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // bits above the register width carry noise, the block must drop them
   task automatic write_masked(input reg_index_type idx, input logic [CSR_DATA_WIDTH-1:0] v,
                               input int w);
      logic [CSR_DATA_WIDTH-1:0] mask;
      logic [CSR_DATA_WIDTH-1:0] noise;
      mask  = ({CSR_DATA_WIDTH{1'b1}} << w);
      noise = {$urandom, $urandom};
      write_reg(idx, (noise & mask) | (v & ~mask));
   endtask

   task automatic load_setup(input logic [ROT_REG_WIDTH-1:0] rx, input logic [ROT_REG_WIDTH-1:0] ry,
                             input logic [ROT_REG_WIDTH-1:0] rz, input logic [BOX_REG_WIDTH-1:0] tr,
                             input logic [BOX_REG_WIDTH-1:0] rlo, input logic [BOX_REG_WIDTH-1:0] rhi,
                             input logic [BOX_REG_WIDTH-1:0] blo, input logic [BOX_REG_WIDTH-1:0] bhi);
      write_masked(REG_ROT_ROW_X, rx, ROT_REG_WIDTH);
      write_masked(REG_ROT_ROW_Y, ry, ROT_REG_WIDTH);
      write_masked(REG_ROT_ROW_Z, rz, ROT_REG_WIDTH);
      write_masked(REG_TRANSLATION, tr, BOX_REG_WIDTH);
      write_masked(REG_ROI_LOW_CORNER, rlo, BOX_REG_WIDTH);
      write_masked(REG_ROI_HIGH_CORNER, rhi, BOX_REG_WIDTH);
      write_masked(REG_BODY_LOW_CORNER, blo, BOX_REG_WIDTH);
      write_masked(REG_BODY_HIGH_CORNER, bhi, BOX_REG_WIDTH);
   endtask

   task automatic send_point(input point_type p);
      int gap;
      gap = draw_gap(req_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_point_x         <= p.x;
      req_point_y         <= p.y;
      req_point_z         <= p.z;
      req_point_intensity <= p.intensity;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      if (point_survives(p)) kept_points = {kept_points, p};
   endtask

   // lets in-flight dropped points leave the pipe before registers change
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (kept_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void compare_field(input string label, input logic signed [63:0] want,
                                         input logic signed [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d got %0d", $time, label, want, got);
         error_count++;
      end
   endfunction

   task automatic check_point();
      point_type want;
      if (kept_points.size() == 0) begin
         $display("%0t: point with none expected x=%0d y=%0d z=%0d intensity=%0d",
                  $time, rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_intensity);
         error_count++;
      end else begin
         want = kept_points.pop_front();
         compare_field("out_x", want.x, rsp_out_x);
         compare_field("out_y", want.y, rsp_out_y);
         compare_field("out_z", want.z, rsp_out_z);
         compare_field("out_intensity", {1'b0, want.intensity}, {1'b0, rsp_out_intensity});
      end
   endtask

   initial begin : response_side
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap(rsp_gap_max);
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         check_point();
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)
             || (csr_valid && csr_ready === 1'b1)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // zero boxes after reset: nothing counts as body and nothing is kept
   task automatic test_reset_boxes();
      send_point(make_point(0, 0, 0, 0));
      send_point(make_point(COORD_MIN, COORD_MIN, COORD_MIN, 0));
      send_point(make_point(COORD_MAX, COORD_MAX, COORD_MAX, 65535));
      send_point(make_point(1, -1, 1, 12345));
      settle();
   endtask

   task automatic test_roi_edges();
      logic [ROT_REG_WIDTH-1:0] ident [NUM_AXES];
      for (int a = 0; a < NUM_AXES; a++) begin
         ident[a] = ROT_REG_WIDTH'(COEF_SCALE) << (a * COEF_WIDTH);
      end
      load_setup(ident[0], ident[1], ident[2], '0, box3(-1000, -1000, -1000),
                 box3(1000, 1000, 1000), '0, '0);
      send_point(make_point(0, 0, 0, 1));
      send_point(make_point(-1000, 0, 0, 2));
      send_point(make_point(-999, 999, -999, 3));
      send_point(make_point(0, 1000, 0, 4));
      send_point(make_point(0, 0, 1001, 5));
      settle();
      // widest region: the extreme coordinates sit on its bounds
      write_masked(REG_ROI_LOW_CORNER, box3(COORD_MIN, COORD_MIN, COORD_MIN), BOX_REG_WIDTH);
      write_masked(REG_ROI_HIGH_CORNER, box3(COORD_MAX, COORD_MAX, COORD_MAX), BOX_REG_WIDTH);
      send_point(make_point(COORD_MIN, 0, 0, 6));
      send_point(make_point(COORD_MIN + 1, COORD_MAX - 1, 0, 7));
      send_point(make_point(0, 0, COORD_MAX, 8));
      settle();
      // inverted on x
      write_masked(REG_ROI_LOW_CORNER, box3(1000, -1000, -1000), BOX_REG_WIDTH);
      write_masked(REG_ROI_HIGH_CORNER, box3(-1000, 1000, 1000), BOX_REG_WIDTH);
      send_point(make_point(0, 0, 0, 9));
      settle();
   endtask

   task automatic test_body_box();
      // tx = y + 100, ty = -x - 200, tz = z + 300
      load_setup(row3(0, int'(COEF_SCALE), 0), row3(-int'(COEF_SCALE), 0, 0),
                 row3(0, 0, int'(COEF_SCALE)), box3(100, -200, 300),
                 box3(COORD_MIN, COORD_MIN, COORD_MIN), box3(COORD_MAX, COORD_MAX, COORD_MAX),
                 box3(-500, -500, -500), box3(500, 500, 500));
      send_point(make_point(0, 0, 0, 21));
      send_point(make_point(0, 400, 0, 22));
      send_point(make_point(0, 399, 0, 23));
      send_point(make_point(-700, 0, 0, 24));
      send_point(make_point(0, 0, -799, 25));
      send_point(make_point(0, 0, -800, 26));
      settle();
      // extreme coefficients and offsets stress the full-width sums
      load_setup(row3(COEF_MAX, COEF_MIN, COEF_MAX), row3(COEF_MIN, COEF_MIN, COEF_MIN),
                 row3(COEF_MAX, COEF_MAX, COEF_MAX), box3(COORD_MIN, COORD_MAX, COORD_MIN),
                 box3(COORD_MIN, COORD_MIN, COORD_MIN), box3(COORD_MAX, COORD_MAX, COORD_MAX),
                 box3(COORD_MIN, COORD_MIN, COORD_MIN), box3(COORD_MAX, COORD_MAX, COORD_MAX));
      send_point(make_point(COORD_MIN + 1, COORD_MIN + 1, COORD_MIN + 1, 31));
      send_point(make_point(COORD_MAX - 1, COORD_MAX - 1, COORD_MAX - 1, 32));
      send_point(make_point(COORD_MAX - 1, COORD_MIN + 1, COORD_MAX - 1, 33));
      settle();
      // every register all ones: boxes collapse to -1..-1
      for (int r = 0; r < NUM_AXES + 5; r++) begin
         write_reg(reg_index_type'(r), {CSR_DATA_WIDTH{1'b1}});
      end
      send_point(make_point(-1, -1, -1, 65535));
      send_point(make_point(0, 0, 0, 0));
      settle();
   endtask

   function automatic int pick_coord(input int a);
      coord_type lo_c;
      coord_type hi_c;
      int        lo;
      int        hi;
      int        v;
      lo_c = roi_lo[a*COORD_WIDTH +: COORD_WIDTH];
      hi_c = roi_hi[a*COORD_WIDTH +: COORD_WIDTH];
      lo   = (lo_c < hi_c) ? lo_c : hi_c;
      hi   = (lo_c < hi_c) ? hi_c : lo_c;
      case ($urandom_range(0, 7))
         0, 1, 2, 3, 4, 5: v = lo + int'($urandom_range(0, hi - lo));
         6: begin
            case ($urandom_range(0, 3))
               0:       v = lo;
               1:       v = lo + 1;
               2:       v = hi - 1;
               default: v = hi;
            endcase
         end
         default: v = int'(coord_type'($urandom));
      endcase
      return v;
   endfunction

   task automatic load_random_setup(input bit free_rotation);
      int rlo [NUM_AXES];
      int rhi [NUM_AXES];
      int blo [NUM_AXES];
      int bhi [NUM_AXES];
      int tr  [NUM_AXES];
      int coef [NUM_AXES][NUM_AXES];
      int turn;
      int tmp;
      turn = $urandom_range(0, 2);
      for (int a = 0; a < NUM_AXES; a++) begin
         rlo[a] = int'($urandom_range(0, 700000)) - 500000;
         rhi[a] = rlo[a] + int'($urandom_range(1, 400000));
         if (rhi[a] > COORD_MAX) rhi[a] = COORD_MAX;
         if ($urandom_range(0, 15) == 0) begin
            tmp    = rlo[a];
            rlo[a] = rhi[a];
            rhi[a] = tmp;
         end
         blo[a] = int'($urandom_range(0, 400000)) - 300000;
         bhi[a] = blo[a] + int'($urandom_range(1, 300000));
         tr[a]  = int'($urandom_range(0, 100000)) - 50000;
         // signed axis permutation unless the coefficients are free
         for (int k = 0; k < NUM_AXES; k++) begin
            if (free_rotation) begin
               coef[a][k] = int'($urandom_range(0, 65535)) + COEF_MIN;
            end else if (k == (a + turn) % NUM_AXES) begin
               coef[a][k] = $urandom_range(0, 1) ? int'(COEF_SCALE) : -int'(COEF_SCALE);
            end else begin
               coef[a][k] = 0;
            end
         end
      end
      load_setup(row3(coef[0][0], coef[0][1], coef[0][2]),
                 row3(coef[1][0], coef[1][1], coef[1][2]),
                 row3(coef[2][0], coef[2][1], coef[2][2]),
                 box3(tr[0], tr[1], tr[2]), box3(rlo[0], rlo[1], rlo[2]),
                 box3(rhi[0], rhi[1], rhi[2]), box3(blo[0], blo[1], blo[2]),
                 box3(bhi[0], bhi[1], bhi[2]));
   endtask

   task automatic test_random_streams();
      int        req_gaps [PHASES] = '{0, 17, 3, 17, 0, 17, 1};
      int        rsp_gaps [PHASES] = '{0, 17, 17, 0, 3, 17, 0};
      point_type p;
      for (int phase = 0; phase < PHASES; phase++) begin
         load_random_setup(phase % 3 == 2);
         req_gap_max = req_gaps[phase];
         rsp_gap_max = rsp_gaps[phase];
         repeat (PHASE_POINTS) begin
            p = make_point(pick_coord(0), pick_coord(1), pick_coord(2),
                           int'($urandom_range(0, 65535)));
            send_point(p);
         end
         settle();
      end
   endtask

   initial begin
      for (int a = 0; a < NUM_AXES; a++) begin
         rot_row[a] = ROT_REG_WIDTH'(COEF_SCALE) << (a * COEF_WIDTH);
      end
      shift_mm    = '0;
      roi_lo      = '0;
      roi_hi      = '0;
      body_lo     = '0;
      body_hi     = '0;
      req_gap_max = 2;
      rsp_gap_max = 2;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_boxes();
      test_roi_edges();
      test_body_box();
      test_random_streams();

      if (error_count == 0 && kept_points.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== point_box_clip_filter_unit.f =====
rtl/pbcf_pkg.sv
rtl/pbcf_csr.sv
rtl/point_box_clip_filter_unit.sv
bench/point_box_clip_filter_unit_test.sv
